// File: rtl/core/echo_ranger_tone_zones_macros.svh
// Assertion helpers used by the checker.
`ifndef ECHO_RANGER_TONE_ZONES_MACROS_SVH
`define ECHO_RANGER_TONE_ZONES_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ERTZ_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ertz check failed");

// Next-cycle implication, disabled while reset is held.
`define ERTZ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ertz check failed");

`endif

// File: rtl/core/ertz_pkg.sv
package ertz_pkg;

    localparam int WIDTH_W  = 16;
    localparam int DIST_W   = 12;
    localparam int PERIOD_W = 16;
    localparam int DUTY_W   = 15;
    localparam int DEN_W    = 15;
    localparam int QUO_W    = 21;
    localparam int ADDR_W   = 5;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_DIST_SCALE   = 3'd0;
    localparam logic [2:0] REG_CNT_MODULUS  = 3'd1;
    localparam logic [2:0] REG_NEAR_LIMIT   = 3'd2;
    localparam logic [2:0] REG_MID_LIMIT    = 3'd3;
    localparam logic [2:0] REG_FAR_LIMIT    = 3'd4;
    localparam logic [2:0] REG_TONE_LIMIT   = 3'd5;
    localparam logic [2:0] REG_SILENT_PER   = 3'd6;

    localparam logic OP_RISE = 1'b0;
    localparam logic OP_FALL = 1'b1;

    typedef logic [WIDTH_W-1:0] width_t;

    typedef struct packed {
        logic [15:0] dist_scale;
        logic [16:0] counter_modulus;
        logic [11:0] near_limit;
        logic [11:0] mid_limit;
        logic [11:0] far_limit;
        logic [7:0]  tone_limit;
        logic [15:0] silent_period;
    } cfg_t;

    typedef struct packed {
        logic   valid;
        width_t width;
    } push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// File: rtl/core/ertz_regs.sv
module ertz_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ertz_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output ertz_pkg::cfg_t             cfg
);

    ertz_pkg::cfg_t cfg_reg;
    logic [2:0]     idx;
    logic           wr_en;

    assign idx   = paddr[ertz_pkg::ADDR_W-1:2];
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dist_scale      <= 16'd17000;
            cfg_reg.counter_modulus <= 17'd26214;
            cfg_reg.near_limit      <= 12'd10;
            cfg_reg.mid_limit       <= 12'd30;
            cfg_reg.far_limit       <= 12'd51;
            cfg_reg.tone_limit      <= 8'd50;
            cfg_reg.silent_period   <= 16'd1048;
        end else if (wr_en) begin
            unique case (idx)
                ertz_pkg::REG_DIST_SCALE:  cfg_reg.dist_scale      <= pwdata[15:0];
                ertz_pkg::REG_CNT_MODULUS: cfg_reg.counter_modulus <= pwdata[16:0];
                ertz_pkg::REG_NEAR_LIMIT:  cfg_reg.near_limit      <= pwdata[11:0];
                ertz_pkg::REG_MID_LIMIT:   cfg_reg.mid_limit       <= pwdata[11:0];
                ertz_pkg::REG_FAR_LIMIT:   cfg_reg.far_limit       <= pwdata[11:0];
                ertz_pkg::REG_TONE_LIMIT:  cfg_reg.tone_limit      <= pwdata[7:0];
                ertz_pkg::REG_SILENT_PER:  cfg_reg.silent_period   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            ertz_pkg::REG_DIST_SCALE:  prdata = {16'd0, cfg_reg.dist_scale};
            ertz_pkg::REG_CNT_MODULUS: prdata = {15'd0, cfg_reg.counter_modulus};
            ertz_pkg::REG_NEAR_LIMIT:  prdata = {20'd0, cfg_reg.near_limit};
            ertz_pkg::REG_MID_LIMIT:   prdata = {20'd0, cfg_reg.mid_limit};
            ertz_pkg::REG_FAR_LIMIT:   prdata = {20'd0, cfg_reg.far_limit};
            ertz_pkg::REG_TONE_LIMIT:  prdata = {24'd0, cfg_reg.tone_limit};
            ertz_pkg::REG_SILENT_PER:  prdata = {16'd0, cfg_reg.silent_period};
            default:                   prdata = 32'd0;
        endcase
    end

endmodule

// File: rtl/core/ertz_front.sv
module ertz_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,
    input  logic [0:0]          s_tuser,
    input  logic [16:0]         counter_modulus,
    input  ertz_pkg::q_stat_t   q_stat,
    output ertz_pkg::push_t     push
);

    logic [15:0]        rise_stamp_reg;
    logic [15:0]        rise_stamp_next;
    logic               accept;
    logic               wrap;
    logic signed [18:0] diff;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign wrap     = s_tdata < rise_stamp_reg;

    // fall - rise (+ modulus on wrap), clamped to 0..65535
    assign diff = $signed({3'd0, s_tdata})
                + $signed(wrap ? {2'd0, counter_modulus} : 19'd0)
                - $signed({3'd0, rise_stamp_reg});

    always_comb begin
        push.valid = accept && (s_tuser[0] == ertz_pkg::OP_FALL);
        if (diff[18]) begin
            push.width = '0;
        end else if (diff[17:16] != 2'd0) begin
            push.width = '1;
        end else begin
            push.width = diff[15:0];
        end
    end

    always_comb begin
        rise_stamp_next = rise_stamp_reg;
        if (accept && (s_tuser[0] == ertz_pkg::OP_RISE)) begin
            rise_stamp_next = s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rise_stamp_reg <= '0;
        end else begin
            rise_stamp_reg <= rise_stamp_next;
        end
    end

endmodule

// File: rtl/core/ertz_queue.sv
module ertz_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  ertz_pkg::push_t    push,
    input  logic               pop,
    output ertz_pkg::width_t   head,
    output ertz_pkg::q_stat_t  stat
);

    ertz_pkg::width_t mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_pop;

    assign stat.full  = count_reg == 2'd2;
    assign stat.empty = count_reg == 2'd0;
    assign head       = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && !stat.empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid) begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (do_pop) begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push.valid && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !push.valid) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            mem_reg[wr_ptr_reg] <= push.width;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/core/ertz_back.sv
module ertz_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  ertz_pkg::cfg_t     cfg,
    input  ertz_pkg::width_t   head,
    input  ertz_pkg::q_stat_t  q_stat,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [63:0]        m_tdata
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL   = 5'b00010,
        S_CLASS = 5'b00100,
        S_DIV   = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t                         state_reg, state_next;
    ertz_pkg::width_t               width_reg;
    logic [31:0]                    prod_reg;
    logic [ertz_pkg::DIST_W-1:0]    dist_cm;
    logic [ertz_pkg::DIST_W-1:0]    dist_reg;
    logic                           red_reg, green_reg, tone_reg;
    logic [ertz_pkg::DEN_W-1:0]     den_reg;
    logic [15:0]                    rem_reg;
    logic [ertz_pkg::QUO_W-1:0]     quo_reg;
    logic [4:0]                     step_reg;
    logic [15:0]                    trial;
    logic                           fit;
    logic [ertz_pkg::PERIOD_W-1:0]  period_reg;
    logic [7:0]                     tone_gap;
    logic                           near_hit, mid_hit, far_hit, tone_hit;
    logic [63:0]                    out_reg;
    logic                           out_valid_reg;
    logic                           out_free;

    assign dist_cm  = prod_reg[31:20];
    assign near_hit = dist_cm < cfg.near_limit;
    assign mid_hit  = dist_cm < cfg.mid_limit;
    assign far_hit  = dist_cm < cfg.far_limit;
    assign tone_hit = dist_cm < {4'd0, cfg.tone_limit};
    assign tone_gap = cfg.tone_limit - dist_cm[7:0];

    // dividend is 2^20: only the first bit brought down is a one
    assign trial = {rem_reg[14:0], step_reg == 5'd20};
    assign fit   = trial >= {1'b0, den_reg};

    assign out_free = !out_valid_reg || m_tready;
    assign pop      = (state_reg == S_IDLE) && !q_stat.empty;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (!q_stat.empty) state_next = S_MUL;
            S_MUL:   state_next = S_CLASS;
            S_CLASS: state_next = tone_hit ? S_DIV : S_OUT;
            S_DIV:   if (step_reg == 5'd0) state_next = S_OUT;
            S_OUT:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_OUT && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && !q_stat.empty) begin
            width_reg <= head;
        end
        if (state_reg == S_MUL) begin
            prod_reg <= 32'(width_reg) * 32'(cfg.dist_scale);
        end
        if (state_reg == S_CLASS) begin
            dist_reg  <= dist_cm;
            red_reg   <= near_hit || mid_hit;
            green_reg <= near_hit || (!mid_hit && far_hit);
            tone_reg  <= tone_hit;
            den_reg   <= {7'd0, tone_gap} * 15'd100;
            rem_reg   <= '0;
            quo_reg   <= '0;
            step_reg  <= 5'd20;
            if (!tone_hit) begin
                period_reg <= cfg.silent_period;
            end
        end
        if (state_reg == S_DIV) begin
            rem_reg  <= fit ? trial - {1'b0, den_reg} : trial;
            quo_reg  <= {quo_reg[ertz_pkg::QUO_W-2:0], fit};
            step_reg <= step_reg - 5'd1;
            if (step_reg == 5'd0) begin
                period_reg <= 16'({quo_reg[ertz_pkg::QUO_W-2:0], fit}) - 16'd1;
            end
        end
        if (state_reg == S_OUT && out_free) begin
            out_reg <= {2'b00,
                        tone_reg ? period_reg[15:1] : {ertz_pkg::DUTY_W{1'b0}},
                        period_reg, tone_reg, green_reg, red_reg,
                        dist_reg, width_reg};
        end
    end

endmodule

// File: rtl/core/echo_ranger_tone_zones.sv
// Echo ranger with proximity zones and buzzer tone.
// Input items (s_ channel): one timer capture per item. s_tuser[0] is the edge
// kind (0 rising, 1 falling), s_tdata the 16-bit counter value. A rising item
// stores its stamp and gives no result; a falling item gives one result.
// Result items (m_ channel): pulse width, distance in cm, LED flags and the
// PWM period/duty for the buzzer (tone period 2^20/((tone_limit-d)*100)-1).
// Registers sit on the APB port at byte address 4*index; pready is tied high.
// A falling item's width is computed on acceptance and queued (2 deep); the
// back end then steps through multiply, zone sort, the 21-step restoring
// divider when a tone is computed, and output. It takes the next width only
// once the output register has taken the last result.
// Reset (synchronous, aresetn low) loads register defaults, clears the stored
// rising stamp to zero and empties queue and output register.
// When the receiver stalls, the output register holds its item, the back end
// waits with the next result, the queue fills and then s_tready drops.
module echo_ranger_tone_zones (
    input  logic        aclk,
    input  logic        aresetn,
    // capture items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] capture_value
    input  logic [0:0]  s_tuser,   // [0] op
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [15:0] pulse_width, [27:16] distance,
                                   // [28] led_red, [29] led_green, [30] tone_on,
                                   // [46:31] tone_period, [61:47] tone_duty
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ertz_pkg::cfg_t    cfg;
    ertz_pkg::push_t   push;
    ertz_pkg::q_stat_t q_stat;
    ertz_pkg::width_t  head;
    logic              pop;

    assign pready = 1'b1;

    ertz_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // front: stamp store and width calculation
    ertz_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .counter_modulus (cfg.counter_modulus),
        .q_stat          (q_stat),
        .push            (push)
    );

    // widths waiting for the back end
    ertz_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .stat    (q_stat)
    );

    // back: scale, zone sort, tone divider, output register
    ertz_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .head     (head),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: rtl/core/ertz_checker.sv
`include "echo_ranger_tone_zones_macros.svh"

module ertz_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // a stalled result holds
    `ERTZ_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))
    // tone duty is half the period
    `ERTZ_ASSERT_NOW(a_duty_half, aclk, aresetn, m_tvalid && m_tdata[30], m_tdata[61:47] == m_tdata[46:32])
    // silent output has zero duty
    `ERTZ_ASSERT_NOW(a_silent_duty, aclk, aresetn, m_tvalid && !m_tdata[30], m_tdata[61:47] == 15'd0)
    // a tone only below 256 cm
    `ERTZ_ASSERT_NOW(a_tone_near, aclk, aresetn, m_tvalid && m_tdata[30], m_tdata[27:24] == 4'd0)

endmodule

bind echo_ranger_tone_zones ertz_checker u_ertz_checker (.*);
